[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    // Operation codes carried on the request channel
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DREAD,
        S_EMIT
    } t_state;

endpackage

[src/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue held in a ring RAM with a front pointer and a
// count. Push/pop at either end, plus a dump that lists every entry.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -------------------------------
//  request   in         i_in_valid / o_in_stall   i_operation, i_value
//  result    out        o_out_valid / i_out_stall o_result_value, o_status, o_last
//
//  A push or pop request passes through accept, ring access and emit steps
//  on its way to the result register. A dump passes through accept and exec,
//  then takes each stored entry in turn through a RAM read step and an emit
//  step. All slot arithmetic goes through one modulo-DEPTH adder; the RAM
//  read latency sets the per-entry dump cost.
//  Reset (synchronous, active low) empties the queue; RAM contents are left
//  as they are. A stalled result register holds the sequencer in its emit
//  step; the next request is taken as soon as the sequencer is idle, even
//  while the last result still waits.
//
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [deq_pkg::OP_W-1:0]      i_operation,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [deq_pkg::DATA_W-1:0] o_result_value,
    output logic [deq_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);      // ring slot width
    localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself

    localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_OFS  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Sequencer state
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [DATA_W-1:0]   r_value, n_value;
    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;

    // Pending result descriptor, turned into an output in the emit step
    logic                r_res_mem, n_res_mem;
    t_status             r_res_status, n_res_status;
    logic                r_res_last, n_res_last;

    // Result register
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    t_status             r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    // Shared slot unit: (front + offset) mod DEPTH
    logic [AW-1:0]       slot_ofs;
    logic [AW:0]         slot_sum;
    logic [AW:0]         slot_wrap;
    logic [AW-1:0]       slot_addr;

    // RAM port
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_wa;
    logic [AW-1:0]       ram_ra;
    logic [DATA_W-1:0]   ram_rd;

    logic [CW-1:0]       cnt_m1;
    logic                out_free;
    logic                q_full;
    logic                q_empty;

    assign slot_sum  = {1'b0, r_front} + {1'b0, slot_ofs};
    assign slot_wrap = (slot_sum >= DEPTH_SUM) ? (slot_sum - DEPTH_SUM) : slot_sum;
    assign slot_addr = slot_wrap[AW-1:0];

    assign cnt_m1   = r_count - CW'(1);
    assign q_full   = (r_count == FULL_CNT);
    assign q_empty  = (r_count == '0);
    assign out_free = !r_out_valid || !i_out_stall;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (r_value),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_res_mem    <= n_res_mem;
        r_res_status <= n_res_status;
        r_res_last   <= n_res_last;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_value      = r_value;
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_mem    = r_res_mem;
        n_res_status = r_res_status;
        n_res_last   = r_res_last;
        // drop the result once the consumer takes it
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        slot_ofs     = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wa       = slot_addr;
        ram_ra       = slot_addr;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_value = i_value;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_mem    = 1'b0;
                n_res_status = ST_OK;
                n_res_last   = 1'b1;
                n_state      = S_EMIT;
                case (r_op) inside
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (q_full) begin
                            n_res_status = ST_OVERFLOW;
                        end else begin
                            slot_ofs = (r_op == OP_PUSH_FRONT) ? LAST_OFS
                                                               : r_count[AW-1:0];
                            ram_we   = 1'b1;
                            if (r_op == OP_PUSH_FRONT) begin
                                n_front = slot_addr;
                            end
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (q_empty) begin
                            n_res_status = ST_UNDERFLOW;
                        end else begin
                            ram_re    = 1'b1;
                            n_res_mem = 1'b1;
                            if (r_op == OP_POP_FRONT) begin
                                // read the front slot, advance front by one
                                ram_ra   = r_front;
                                slot_ofs = AW'(1);
                                n_front  = slot_addr;
                            end else begin
                                slot_ofs = cnt_m1[AW-1:0];
                            end
                            n_count = cnt_m1;
                        end
                    end
                    OP_DUMP: begin
                        n_idx   = '0;
                        n_state = q_empty ? S_IDLE : S_DREAD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_DREAD: begin
                slot_ofs     = r_idx;
                ram_re       = 1'b1;
                n_res_mem    = 1'b1;
                n_res_status = ST_OK;
                n_res_last   = ((CW'(r_idx) + CW'(1)) == r_count);
                n_state      = S_EMIT;
            end

            S_EMIT: begin
                // hold until the result register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_mem ? ram_rd : '0;
                    n_out_status = r_res_status;
                    n_out_last   = r_res_last;
                    if (r_op == OP_DUMP && !r_res_last) begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_DREAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

endmodule
